>>> src/sdh_pkg.sv
// Package with the constants and handoff type shared by the salted hash expander.
package sdh_pkg;

    localparam int HASH_BYTES = 32;

    localparam int ACC_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int SHIFT_W = 5;
    localparam int OUT_W   = 16;

    localparam logic [ACC_W-1:0] ACC_INIT = 32'd5381;
    localparam logic [ACC_W-1:0] LCG_MUL  = 32'd1103515245;
    localparam logic [ACC_W-1:0] LCG_ADD  = 32'd12345;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(HASH_BYTES - 1);

    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] acc;
    } seed_t;

endpackage

>>> src/sdh_absorb.sv
// Byte absorber: djb2 accumulator and the held seed of a finished message.
module sdh_absorb
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sdh_pkg::BYTE_W-1:0] in_data,
    input  logic                       in_last,
    output sdh_pkg::seed_t             seed,
    input  logic                       seed_take
);

    logic [sdh_pkg::ACC_W-1:0] acc_reg;
    logic [sdh_pkg::ACC_W-1:0] acc_next;
    logic [sdh_pkg::ACC_W-1:0] seed_acc_reg;
    logic [sdh_pkg::ACC_W-1:0] seed_acc_next;
    logic                      seed_valid_reg;
    logic                      seed_valid_next;
    logic [sdh_pkg::ACC_W-1:0] acc_mix;
    logic                      accept;

    assign in_ready = !seed_valid_reg || seed_take;
    assign accept   = in_valid && in_ready;
    assign acc_mix  = (acc_reg << 5) + acc_reg
                    + {{(sdh_pkg::ACC_W-sdh_pkg::BYTE_W){1'b0}}, in_data};

    always_comb
    begin
        acc_next        = acc_reg;
        seed_acc_next   = seed_acc_reg;
        seed_valid_next = seed_valid_reg;
        if (seed_take)
        begin
            seed_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (in_last)
            begin
                acc_next        = sdh_pkg::ACC_INIT;
                seed_acc_next   = acc_mix;
                seed_valid_next = 1'b1;
            end
            else
            begin
                acc_next = acc_mix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= sdh_pkg::ACC_INIT;
            seed_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            seed_valid_reg <= seed_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_acc_reg <= seed_acc_next;
    end

    assign seed.valid = seed_valid_reg;
    assign seed.acc   = seed_acc_reg;

endmodule

>>> src/sdh_expand.sv
// Digest expander: LCG sequence, byte selection and the output register.
module sdh_expand
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sdh_pkg::seed_t             seed,
    output logic                       seed_take,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sdh_pkg::OUT_W-1:0]  out_data,
    output logic                       out_last
);

    logic                         busy_reg;
    logic                         busy_next;
    logic [sdh_pkg::ACC_W-1:0]    lcg_reg;
    logic [sdh_pkg::ACC_W-1:0]    lcg_next;
    logic [sdh_pkg::INDEX_W-1:0]  idx_reg;
    logic [sdh_pkg::INDEX_W-1:0]  idx_next;
    logic                         ovalid_reg;
    logic                         ovalid_next;
    logic [sdh_pkg::BYTE_W-1:0]   obyte_reg;
    logic [sdh_pkg::BYTE_W-1:0]   obyte_next;
    logic [sdh_pkg::INDEX_W-1:0]  oidx_reg;
    logic [sdh_pkg::INDEX_W-1:0]  oidx_next;
    logic                         olast_reg;
    logic                         olast_next;
    logic                         step;
    logic                         at_last;
    logic [sdh_pkg::ACC_W-1:0]    shifted;
    logic [sdh_pkg::ACC_W-1:0]    lcg_step;

    assign step      = busy_reg && (!ovalid_reg || out_ready);
    assign at_last   = (idx_reg == sdh_pkg::LAST_INDEX);
    assign seed_take = seed.valid && (!busy_reg || (step && at_last));
    assign shifted   = lcg_reg >> idx_reg[sdh_pkg::SHIFT_W-1:0];
    assign lcg_step  = lcg_reg * sdh_pkg::LCG_MUL + sdh_pkg::LCG_ADD;

    always_comb
    begin
        busy_next   = busy_reg;
        lcg_next    = lcg_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        oidx_next   = oidx_reg;
        olast_next  = olast_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (step)
        begin
            ovalid_next = 1'b1;
            obyte_next  = shifted[sdh_pkg::BYTE_W-1:0];
            oidx_next   = idx_reg;
            olast_next  = at_last;
            lcg_next    = lcg_step;
            idx_next    = idx_reg + 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (seed_take)
        begin
            busy_next = 1'b1;
            lcg_next  = seed.acc;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg   <= lcg_next;
        obyte_reg <= obyte_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = {{(sdh_pkg::OUT_W-sdh_pkg::INDEX_W-sdh_pkg::BYTE_W){1'b0}},
                        oidx_reg, obyte_reg};
    assign out_last  = olast_reg;

endmodule

>>> src/salted_djb2_hash_expander_top.sv
// Top level of the salted djb2 hash expander.
//
//  Channel   Direction  Payload                                       Marker
//  s_axis    in         tdata[7:0] data_byte                          tlast final_byte
//  m_axis    out        tdata[7:0] digest_byte, [13:8] digest_index   tlast digest_last
//
// One input item is absorbed per cycle by a shift-add on the accumulator while
// s_axis_tready is high. A final item's hash goes via the seed, LCG and output
// registers to the first digest item; HASH_BYTES items go out at one per cycle
// while m_axis_tready is high. Input flows during a burst; a second final item
// is held as the next seed, and further input waits until the burst registers
// its last item. Reset sets the accumulator to 5381 and empties both stages.
module salted_djb2_hash_expander_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] digest_byte, [13:8] digest_index, [15:14] zero
    output logic        m_axis_tlast
);

    sdh_pkg::seed_t seed;
    logic           seed_take;

    sdh_absorb u_absorb
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .seed      (seed),
        .seed_take (seed_take)
    );

    sdh_expand u_expand
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed),
        .seed_take (seed_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
